// ===== design/hasp_pkg.sv =====
`default_nettype none
package hasp_pkg;

  localparam int unsigned OVERSAMPLE    = 16;
  localparam int unsigned AVERAGE_DEPTH = 32;
  localparam int unsigned PWM_DIVIDE    = 8;
  localparam int unsigned SAMPLE_BITS   = 10;

  localparam int unsigned ADC_W  = 10;
  localparam int unsigned DUTY_W = 8;
  localparam int unsigned AVG_W  = 14;
  localparam int unsigned SUM_W  = 19;
  localparam int unsigned TICK_W = (PWM_DIVIDE > 1) ? $clog2(PWM_DIVIDE) : 1;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  // Sequencer phase codes.
  localparam logic [1:0] PH_START_HOT = 2'd0;
  localparam logic [1:0] PH_READ_HOT  = 2'd1;
  localparam logic [1:0] PH_START_BED = 2'd2;
  localparam logic [1:0] PH_READ_BED  = 2'd3;

  typedef struct packed {
    logic             conv_start;
    logic             conv_channel;
    logic             averages_valid;
    logic [AVG_W-1:0] hotend_average;
    logic [AVG_W-1:0] bed_average;
  } samp_res_t;

  typedef struct packed {
    logic hotend_heater_on;
    logic bed_heater_on;
  } pins_t;

endpackage
`default_nettype wire

// ===== design/hasp_sampler.sv =====
`default_nettype none
module hasp_sampler (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      advance,
  input  wire logic [hasp_pkg::ADC_W-1:0] adc_sample,
  output hasp_pkg::samp_res_t            res
);
  import hasp_pkg::*;

  logic [1:0]       phase_r, phase_nxt;
  logic [SUM_W-1:0] hot_sum_r, hot_sum_nxt;
  logic [SUM_W-1:0] bed_sum_r, bed_sum_nxt;
  logic [SUM_W-1:0] folded;
  logic [SUM_W:0]   scaled;

  // Exponential running sum: sum - sum/depth + sample*oversample.
  // The sum settles at depth times the scaled sample, so it always fits.
  function automatic logic [SUM_W-1:0] fold(input logic [SUM_W-1:0] sum,
                                            input logic [SUM_W:0]   add);
    logic [SUM_W:0] s;
    s = {1'b0, sum};
    return SUM_W'(s - (SUM_W+1)'(s / AVERAGE_DEPTH) + add);
  endfunction

  always_comb begin
    scaled = (SUM_W+1)'({{(SUM_W+1-SAMPLE_BITS){1'b0}},
                         adc_sample[SAMPLE_BITS-1:0]} * OVERSAMPLE);
    folded = fold((phase_r == PH_READ_HOT) ? hot_sum_r : bed_sum_r, scaled);
  end

  always_comb begin
    phase_nxt   = phase_r + 2'd1;
    hot_sum_nxt = hot_sum_r;
    bed_sum_nxt = bed_sum_r;
    res         = '0;
    unique case (phase_r)
      PH_START_HOT: begin
        res.conv_start = 1'b1;
      end
      PH_READ_HOT: begin
        hot_sum_nxt = folded;
      end
      PH_START_BED: begin
        res.conv_start   = 1'b1;
        res.conv_channel = 1'b1;
      end
      PH_READ_BED: begin
        bed_sum_nxt        = folded;
        res.averages_valid = 1'b1;
        res.hotend_average = AVG_W'(hot_sum_r / AVERAGE_DEPTH);
        res.bed_average    = AVG_W'(folded / AVERAGE_DEPTH);
      end
      default: begin
        phase_nxt = PH_START_HOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START_HOT;
      hot_sum_r <= '0;
      bed_sum_r <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      hot_sum_r <= hot_sum_nxt;
      bed_sum_r <= bed_sum_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/hasp_pwm.sv =====
`default_nettype none
module hasp_pwm (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       advance,
  input  wire logic [hasp_pkg::DUTY_W-1:0] hotend_duty,
  input  wire logic [hasp_pkg::DUTY_W-1:0] bed_duty,
  output hasp_pkg::pins_t                 pins
);
  import hasp_pkg::*;

  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [7:0]        pwm_r, pwm_nxt;
  pins_t             pins_r, pins_nxt;
  logic              update;

  always_comb begin
    update   = (tick_r == TICK_W'(PWM_DIVIDE - 1));
    tick_nxt = update ? '0 : tick_r + TICK_W'(1);
    pwm_nxt  = pwm_r;
    pins_nxt = pins_r;
    if (update) begin
      pins_nxt.hotend_heater_on = (hotend_duty != '0) && (pwm_r <= hotend_duty);
      pins_nxt.bed_heater_on    = (bed_duty != '0) && (pwm_r <= bed_duty);
      pwm_nxt                   = pwm_r + 8'd1;
    end
    // The result carries the pin levels after this tick.
    pins = pins_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      pwm_r  <= '0;
      pins_r <= '0;
    end else if (advance) begin
      tick_r <= tick_nxt;
      pwm_r  <= pwm_nxt;
      pins_r <= pins_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/heater_adc_sampler_soft_pwm.sv =====
`default_nettype none
// Throughput: one word per cycle while out_tready is high or the output is empty.
// The state update is a single add/subtract and a pair of compares, done between
// the sequencer state and output register; a result shows the cycle after accept.
// Reset (rst_n low, synchronous): sequencer at the hotend start phase, sums,
// PWM divider, counter and pins cleared, output register empty.
module heater_adc_sampler_soft_pwm (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // adc_sample[9:0], hotend_duty[17:10], bed_duty[25:18], zero fill above
  input  wire logic [hasp_pkg::IN_DATA_W-1:0]    in_tdata,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // conv_start[0], conv_channel[1], hotend_heater_on[2], bed_heater_on[3],
  // averages_valid[4], hotend_average[18:5], bed_average[32:19], zero fill above
  output      logic [hasp_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import hasp_pkg::*;

  logic                      accept;
  samp_res_t                 samp;
  pins_t                     pins;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r, out_data_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  hasp_sampler u_sampler (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (accept),
    .adc_sample (in_tdata[ADC_W-1:0]),
    .res        (samp)
  );

  hasp_pwm u_pwm (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (accept),
    .hotend_duty (in_tdata[ADC_W +: DUTY_W]),
    .bed_duty    (in_tdata[ADC_W+DUTY_W +: DUTY_W]),
    .pins        (pins)
  );

  assign out_data_nxt = {7'd0, samp.bed_average, samp.hotend_average,
                         samp.averages_valid, pins.bed_heater_on,
                         pins.hotend_heater_on, samp.conv_channel, samp.conv_start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
